// ===== sv/source_text_comment_quote_filter_defines.svh =====
// Assertion macros shared by the filter RTL.
`ifndef SOURCE_TEXT_COMMENT_QUOTE_FILTER_DEFINES_SVH
`define SOURCE_TEXT_COMMENT_QUOTE_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SCTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sctf assertion failed");
// Next-cycle implication.
`define SCTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sctf assertion failed");
`else
`define SCTF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCTF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/sctf_pkg.sv =====
package sctf_pkg;

	// Counter widths
	localparam int DEPTH_BITS = 16;
	localparam int LINE_BITS  = 32;

	localparam logic signed [DEPTH_BITS-1:0] BRACE_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] BRACE_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic [DEPTH_BITS-1:0] BLOCK_MAX = '1;
	localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

	// Queue sizes (depths are powers of two so pointers wrap on their own)
	localparam int FQ_DEPTH   = 2;
	localparam int FQ_AW      = 1;
	localparam int FQ_CW      = 2;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;
	localparam int OUTQ_CW    = 3;

	// Register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_STRIP_ENABLE   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_STRIP_AUTO     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_STRIP_COMMENTS = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_STRIP_QUOTES   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_STRIP_WS       = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_COMPRESS_WS    = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_CASE_SENSITIVE = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_FOLD_UPPER     = 3'd7;

	// Characters
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT_LO  = 8'h09;
	localparam logic [7:0] CH_VT_HI  = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CASE_OFS  = 8'd32;

	typedef enum logic [1:0] {
		ST_CHAR    = 2'd0,
		ST_END     = 2'd1,
		ST_BAD_ESC = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		status_t            status;
		logic               last_of_run;
		logic [31:0]        line_number;
		logic signed [15:0] brace_level;
	} out_item_t;

	typedef struct packed {
		logic strip_enable;
		logic strip_auto;
		logic strip_comments;
		logic strip_quotes;
		logic strip_whitespace;
		logic compress_whitespace;
		logic case_sensitive;
		logic fold_upper;
	} cfg_t;

	// Byte class flags produced by the front end
	typedef struct packed {
		logic nl;
		logic lbrace;
		logic rbrace;
		logic dq;
		logic sq;
		logic slash;
		logic star;
		logic bsl;
		logic ws;
		logic upper;
		logic lower;
		logic esc_r;
		logic esc_n;
		logic esc_t;
	} char_cls_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eod;
		char_cls_t  cls;
	} cls_item_t;

	// Results from the back end to the output queue
	typedef struct packed {
		logic [1:0] n;
		out_item_t  a;
		out_item_t  b;
	} push_t;

endpackage

// ===== sv/sctf_front.sv =====
module sctf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  sctf_pkg::in_item_t   src_data,
	output logic                 q_valid,
	input  logic                 q_ready,
	output sctf_pkg::cls_item_t  q_item
);

	sctf_pkg::cls_item_t              fifo_q [sctf_pkg::FQ_DEPTH];
	logic [sctf_pkg::FQ_AW-1:0]       wr_ptr_q;
	logic [sctf_pkg::FQ_AW-1:0]       rd_ptr_q;
	logic [sctf_pkg::FQ_CW-1:0]       count_q;
	sctf_pkg::cls_item_t              cls_item;
	logic                             push;
	logic                             pop;

	// Decode the byte into the classes the back end tests
	always_comb begin
		logic [7:0] b;
		b = src_data.in_byte;
		cls_item.b          = b;
		cls_item.eod        = src_data.end_of_data;
		cls_item.cls.nl     = (b == sctf_pkg::CH_NL);
		cls_item.cls.lbrace = (b == sctf_pkg::CH_LBRACE);
		cls_item.cls.rbrace = (b == sctf_pkg::CH_RBRACE);
		cls_item.cls.dq     = (b == sctf_pkg::CH_DQ);
		cls_item.cls.sq     = (b == sctf_pkg::CH_SQ);
		cls_item.cls.slash  = (b == sctf_pkg::CH_SLASH);
		cls_item.cls.star   = (b == sctf_pkg::CH_STAR);
		cls_item.cls.bsl    = (b == sctf_pkg::CH_BSL);
		cls_item.cls.ws     = (b == sctf_pkg::CH_SPACE) ||
			(b >= sctf_pkg::CH_VT_LO && b <= sctf_pkg::CH_VT_HI);
		cls_item.cls.upper  = (b >= sctf_pkg::CH_UC_A && b <= sctf_pkg::CH_UC_Z);
		cls_item.cls.lower  = (b >= sctf_pkg::CH_LC_A && b <= sctf_pkg::CH_LC_Z);
		cls_item.cls.esc_r  = (b == sctf_pkg::CH_LC_R);
		cls_item.cls.esc_n  = (b == sctf_pkg::CH_LC_N);
		cls_item.cls.esc_t  = (b == sctf_pkg::CH_LC_T);
	end

	assign src_ready = (count_q != sctf_pkg::FQ_CW'(sctf_pkg::FQ_DEPTH));
	assign q_valid   = (count_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];
	assign push      = src_valid && src_ready;
	assign pop       = q_valid && q_ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls_item;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + sctf_pkg::FQ_CW'(push) - sctf_pkg::FQ_CW'(pop);
		end
	end

endmodule

// ===== sv/sctf_back.sv =====
`include "source_text_comment_quote_filter_defines.svh"

module sctf_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sctf_pkg::cfg_t                     cfg,
	input  logic                               q_valid,
	output logic                               q_ready,
	input  sctf_pkg::cls_item_t                q_item,
	input  logic [sctf_pkg::OUTQ_CW-1:0]       out_free,
	output sctf_pkg::push_t                    push
);

	localparam int DB = sctf_pkg::DEPTH_BITS;
	localparam int LB = sctf_pkg::LINE_BITS;

	// Lookahead and tracking state
	logic [7:0]                held_q;
	sctf_pkg::char_cls_t       held_cls_q;
	logic                      held_valid_q;
	logic [7:0]                prev_q;
	logic                      prev_valid_q;
	logic                      lc_q;
	logic [DB-1:0]             blk_q;
	logic signed [DB-1:0]      brace_q;
	logic                      dq_q;
	logic                      sq_q;
	logic                      pws_q;
	logic [LB-1:0]             line_q;

	logic                      take;
	logic                      nv;
	sctf_pkg::char_cls_t       cc;
	sctf_pkg::char_cls_t       nc;
	logic                      last_bs, last_star, last_slash;
	logic                      lc1, incom1, inq;
	logic signed [DB-1:0]      brace_n;
	logic                      dq_n, sq_n, lc_n;
	logic [DB-1:0]             blk_n;
	logic                      open_line, open_blk, close_blk;
	logic                      incom_n, inq_n;
	logic                      emit, used, esc_nl, kill_prev;
	logic [7:0]                ob;
	sctf_pkg::status_t         st;
	logic [LB-1:0]             line1, line2;
	logic [LB-1:0]             line_post;
	logic signed [DB-1:0]      brace_post;
	sctf_pkg::out_item_t       proc_item, end_item;

	assign q_ready = (out_free >= sctf_pkg::OUTQ_CW'(2));
	assign take    = q_valid && q_ready;
	assign nv      = !q_item.eod;
	assign cc      = held_cls_q;
	assign nc      = q_item.cls;

	// Tracking updates for the held byte with the new byte as successor
	always_comb begin
		last_bs    = prev_valid_q && (prev_q == sctf_pkg::CH_BSL);
		last_star  = prev_valid_q && (prev_q == sctf_pkg::CH_STAR);
		last_slash = prev_valid_q && (prev_q == sctf_pkg::CH_SLASH);

		lc1    = cc.nl ? 1'b0 : lc_q;
		incom1 = lc1 || (blk_q != '0);
		inq    = dq_q || sq_q;

		brace_n = brace_q;
		if (cc.lbrace && !incom1 && !inq && brace_q != sctf_pkg::BRACE_MAX) begin
			brace_n = brace_q + DB'(1);
		end else if (cc.rbrace && !incom1 && !inq && brace_q != sctf_pkg::BRACE_MIN) begin
			brace_n = brace_q - DB'(1);
		end

		dq_n = dq_q;
		if (cc.dq && !incom1 && !sq_q) begin
			dq_n = !(dq_q && !last_bs);
		end
		sq_n = sq_q;
		if (cc.sq && !incom1 && !dq_n) begin
			sq_n = !(sq_q && !last_bs);
		end

		open_line = cc.slash && !last_star && !inq && nv && nc.slash && (blk_q == '0);
		open_blk  = cc.slash && !last_star && !inq && nv && nc.star && !lc1 &&
			(blk_q != sctf_pkg::BLOCK_MAX);
		close_blk = cc.star && nv && nc.slash && !last_slash && !inq && !lc1 &&
			(blk_q != '0);

		lc_n = lc1 || open_line;
		blk_n = blk_q;
		if (open_blk) begin
			blk_n = blk_q + DB'(1);
		end else if (close_blk) begin
			blk_n = blk_q - DB'(1);
		end

		incom_n = lc_n || (blk_n != '0);
		inq_n   = dq_n || sq_n;
	end

	// Output decision for the held byte
	always_comb begin
		emit      = 1'b0;
		used      = 1'b0;
		esc_nl    = 1'b0;
		kill_prev = 1'b0;
		ob        = held_q;
		st        = sctf_pkg::ST_CHAR;
		priority if (!cfg.strip_enable || (cfg.strip_auto && brace_n != '0)) begin
			emit = 1'b1;
		end else if (cfg.strip_comments && incom_n) begin
			emit = 1'b0;
		end else if (cfg.strip_comments && !inq_n &&
			((cc.star && nv && nc.slash) || (last_star && cc.slash))) begin
			emit = 1'b0;
		end else if (cfg.strip_whitespace && cc.ws && !inq_n) begin
			emit = 1'b0;
		end else if (cfg.compress_whitespace && cc.ws) begin
			emit = !pws_q;
			ob   = sctf_pkg::CH_SPACE;
		end else if (cfg.strip_quotes && (cc.dq || cc.sq)) begin
			emit = 1'b0;
		end else if (inq_n && cc.bsl) begin
			// Quoted backslash: translate the pair
			emit      = 1'b1;
			kill_prev = 1'b1;
			if (!nv) begin
				ob = 8'h00;
				st = sctf_pkg::ST_BAD_ESC;
			end else begin
				used = 1'b1;
				priority if (nc.esc_r) begin
					ob = sctf_pkg::CH_CR;
				end else if (nc.esc_n) begin
					ob = sctf_pkg::CH_NL;
				end else if (nc.esc_t) begin
					ob = sctf_pkg::CH_TAB;
				end else if (nc.nl) begin
					ob     = sctf_pkg::CH_NL;
					esc_nl = 1'b1;
				end else if (nc.bsl || nc.sq || nc.dq) begin
					ob = q_item.b;
				end else begin
					ob = q_item.b;
					st = sctf_pkg::ST_BAD_ESC;
				end
			end
		end else if (!cfg.case_sensitive && !inq_n) begin
			emit = 1'b1;
			if (cfg.fold_upper && cc.lower) begin
				ob = held_q - sctf_pkg::CASE_OFS;
			end else if (!cfg.fold_upper && cc.upper) begin
				ob = held_q + sctf_pkg::CASE_OFS;
			end
		end else begin
			emit = 1'b1;
		end
	end

	// Line count, up to two saturating bumps
	always_comb begin
		line1 = line_q;
		if (cc.nl && line_q != sctf_pkg::LINE_MAX) begin
			line1 = line_q + LB'(1);
		end
		line2 = line1;
		if (esc_nl && line1 != sctf_pkg::LINE_MAX) begin
			line2 = line1 + LB'(1);
		end
		line_post  = held_valid_q ? line2 : line_q;
		brace_post = held_valid_q ? brace_n : brace_q;
	end

	// Result items
	always_comb begin
		proc_item.out_byte    = ob;
		proc_item.status      = st;
		proc_item.last_of_run = !q_item.eod;
		proc_item.line_number = 32'(line_post);
		proc_item.brace_level = 16'(brace_post);
		end_item.out_byte     = 8'h00;
		end_item.status       = sctf_pkg::ST_END;
		end_item.last_of_run  = 1'b1;
		end_item.line_number  = 32'(line_post);
		end_item.brace_level  = 16'(brace_post);

		push.a = proc_item;
		push.b = end_item;
		push.n = 2'd0;
		if (take) begin
			if (q_item.eod) begin
				if (held_valid_q && emit) begin
					push.n = 2'd2;
				end else begin
					push.a = end_item;
					push.n = 2'd1;
				end
			end else if (held_valid_q && emit) begin
				push.n = 2'd1;
			end
		end
	end

	// State update per taken item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_cls_q   <= '0;
			held_valid_q <= 1'b0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			lc_q         <= 1'b0;
			blk_q        <= '0;
			brace_q      <= '0;
			dq_q         <= 1'b0;
			sq_q         <= 1'b0;
			pws_q        <= 1'b0;
			line_q       <= LB'(1);
		end else if (take) begin
			if (held_valid_q) begin
				lc_q         <= lc_n;
				blk_q        <= blk_n;
				brace_q      <= brace_n;
				dq_q         <= dq_n;
				sq_q         <= sq_n;
				line_q       <= line2;
				pws_q        <= cc.ws;
				prev_q       <= kill_prev ? 8'h00 : held_q;
				prev_valid_q <= !kill_prev;
			end
			if (q_item.eod) begin
				held_q       <= '0;
				held_valid_q <= 1'b0;
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
				pws_q        <= 1'b0;
			end else if (held_valid_q && used) begin
				held_q       <= '0;
				held_valid_q <= 1'b0;
			end else begin
				held_q       <= q_item.b;
				held_cls_q   <= q_item.cls;
				held_valid_q <= 1'b1;
			end
		end
	end

	`SCTF_ASSERT_NEXT(a_eod_flushes, clk, arst_n, take && q_item.eod, !held_valid_q && !prev_valid_q && !pws_q)
	`SCTF_ASSERT_NOW(a_eod_reports, clk, arst_n, take && q_item.eod, push.n != 2'd0)
	`SCTF_ASSERT_NOW(a_empty_step, clk, arst_n, take && !q_item.eod && !held_valid_q, push.n == 2'd0)

endmodule

// ===== sv/sctf_outq.sv =====
`include "source_text_comment_quote_filter_defines.svh"

module sctf_outq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sctf_pkg::push_t                push,
	output logic [sctf_pkg::OUTQ_CW-1:0]   out_free,
	output logic                           dst_valid,
	input  logic                           dst_ready,
	output sctf_pkg::out_item_t            dst_data
);

	sctf_pkg::out_item_t               mem_q [sctf_pkg::OUTQ_DEPTH];
	logic [sctf_pkg::OUTQ_AW-1:0]      wr_ptr_q;
	logic [sctf_pkg::OUTQ_AW-1:0]      rd_ptr_q;
	logic [sctf_pkg::OUTQ_CW-1:0]      count_q;
	logic [sctf_pkg::OUTQ_AW-1:0]      wr_ptr_p1;
	logic                              pop;

	assign out_free  = sctf_pkg::OUTQ_CW'(sctf_pkg::OUTQ_DEPTH) - count_q;
	assign dst_valid = (count_q != '0);
	assign dst_data  = mem_q[rd_ptr_q];
	assign pop       = dst_valid && dst_ready;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	// Up to two writes per cycle
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.b;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sctf_pkg::OUTQ_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + sctf_pkg::OUTQ_CW'(push.n) - sctf_pkg::OUTQ_CW'(pop);
		end
	end

	`SCTF_ASSERT_NOW(a_no_overflow, clk, arst_n, push.n != 2'd0, sctf_pkg::OUTQ_CW'(push.n) <= out_free)
	`SCTF_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= sctf_pkg::OUTQ_CW'(sctf_pkg::OUTQ_DEPTH))

endmodule

// ===== sv/source_text_comment_quote_filter.sv =====
// Path: each accepted item is registered in the front queue; the results of a byte
// are written to the output queue when the back end takes the item completing it.
// Throughput: one input item per cycle while the output queue has room for two;
// an end marker behind an emitted held byte gives two results, sent one by one.
// Reset (arst_n low, asynchronous): tracking cleared, line count one, registers to
// defaults, queues empty; no clearing pass, items accepted right after reset.
module source_text_comment_quote_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  src_valid,
	output logic                                  src_ready,
	input  sctf_pkg::in_item_t                    src_data,
	output logic                                  dst_valid,
	input  logic                                  dst_ready,
	output sctf_pkg::out_item_t                   dst_data,
	input  logic                                  cfg_we,
	input  logic [sctf_pkg::CFG_IW-1:0]           cfg_index,
	input  logic                                  cfg_data
);

	sctf_pkg::cfg_t                    cfg_q;
	logic                              q_valid;
	logic                              q_ready;
	sctf_pkg::cls_item_t               q_item;
	logic [sctf_pkg::OUTQ_CW-1:0]      out_free;
	sctf_pkg::push_t                   push;

	// Mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_enable        <= 1'b1;
			cfg_q.strip_auto          <= 1'b1;
			cfg_q.strip_comments      <= 1'b1;
			cfg_q.strip_quotes        <= 1'b1;
			cfg_q.strip_whitespace    <= 1'b1;
			cfg_q.compress_whitespace <= 1'b0;
			cfg_q.case_sensitive      <= 1'b1;
			cfg_q.fold_upper          <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sctf_pkg::CFG_STRIP_ENABLE:   cfg_q.strip_enable        <= cfg_data;
				sctf_pkg::CFG_STRIP_AUTO:     cfg_q.strip_auto          <= cfg_data;
				sctf_pkg::CFG_STRIP_COMMENTS: cfg_q.strip_comments      <= cfg_data;
				sctf_pkg::CFG_STRIP_QUOTES:   cfg_q.strip_quotes        <= cfg_data;
				sctf_pkg::CFG_STRIP_WS:       cfg_q.strip_whitespace    <= cfg_data;
				sctf_pkg::CFG_COMPRESS_WS:    cfg_q.compress_whitespace <= cfg_data;
				sctf_pkg::CFG_CASE_SENSITIVE: cfg_q.case_sensitive      <= cfg_data;
				sctf_pkg::CFG_FOLD_UPPER:     cfg_q.fold_upper          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sctf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	sctf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.out_free (out_free),
		.push     (push)
	);

	sctf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_free  (out_free),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

endmodule

// ===== verif/tb_source_text_comment_quote_filter.sv =====
module tb_source_text_comment_quote_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 6;
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_LIMIT    = 2000;
	localparam int LONG_HOLD      = 100;
	localparam int HOLD_AFTER     = 200;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_ready;
	sctf_pkg::in_item_t  src_data = '0;
	logic      dst_valid;
	logic      dst_ready = 1'b0;
	sctf_pkg::out_item_t dst_data;
	logic      cfg_we = 1'b0;
	logic [sctf_pkg::CFG_IW-1:0] cfg_index = '0;
	logic      cfg_data = 1'b0;

	source_text_comment_quote_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Shadow of the filter state and mode registers
	sctf_pkg::cfg_t     modes = 8'b1111_1010;
	logic [7:0]         la_byte = '0;
	bit                 la_full = 1'b0;
	logic [7:0]         prior_byte = '0;
	bit                 prior_known = 1'b0;
	bit                 line_cmt_on = 1'b0;
	logic [15:0]        block_depth = '0;
	logic signed [15:0] brace_depth = '0;
	bit                 dq_open = 1'b0;
	bit                 sq_open = 1'b0;
	bit                 prior_ws = 1'b0;
	logic [31:0]        line_count = 32'd1;

	sctf_pkg::in_item_t  bytes_to_send[$];
	sctf_pkg::out_item_t byte_results_due[$];
	int        errors = 0;
	int        bytes_taken = 0;
	int        phase_items = 0;

	function automatic bit commented();
		return line_cmt_on || block_depth != 0;
	endfunction

	function automatic bit quoted();
		return dq_open || sq_open;
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == sctf_pkg::CH_SPACE ||
			(c >= sctf_pkg::CH_VT_LO && c <= sctf_pkg::CH_VT_HI);
	endfunction

	function automatic void bump_lines();
		if (line_count != sctf_pkg::LINE_MAX)
			line_count = line_count + 32'd1;
	endfunction

	function automatic sctf_pkg::out_item_t make_result(logic [7:0] b,
		sctf_pkg::status_t st);
		sctf_pkg::out_item_t r;
		r.out_byte = b;
		r.status = st;
		r.last_of_run = 1'b0;
		r.line_number = line_count;
		r.brace_level = brace_depth;
		return r;
	endfunction

	// Process byte c with its successor nx (present when nv); at most one result
	task automatic scan_byte(input logic [7:0] c, input bit nv, input logic [7:0] nx,
		output bit got, output sctf_pkg::out_item_t r, output bit used);
		bit bs_before, star_before, slash_before, ws, ws_before;
		logic [7:0] folded;
		bs_before = prior_known && prior_byte == sctf_pkg::CH_BSL;
		star_before = prior_known && prior_byte == sctf_pkg::CH_STAR;
		slash_before = prior_known && prior_byte == sctf_pkg::CH_SLASH;
		got = 1'b0;
		used = 1'b0;
		r = '0;

		// tracking state
		if (c == sctf_pkg::CH_NL) begin
			line_cmt_on = 1'b0;
			bump_lines();
		end
		if (c == sctf_pkg::CH_LBRACE && !commented() && !quoted() &&
			brace_depth != sctf_pkg::BRACE_MAX)
			brace_depth = brace_depth + 16'sd1;
		if (c == sctf_pkg::CH_RBRACE && !commented() && !quoted() &&
			brace_depth != sctf_pkg::BRACE_MIN)
			brace_depth = brace_depth - 16'sd1;
		if (c == sctf_pkg::CH_DQ && !commented() && !sq_open)
			dq_open = !(dq_open && !bs_before);
		if (c == sctf_pkg::CH_SQ && !commented() && !dq_open)
			sq_open = !(sq_open && !bs_before);
		if (c == sctf_pkg::CH_SLASH && !star_before && !quoted()) begin
			if (nv && nx == sctf_pkg::CH_SLASH && block_depth == 0)
				line_cmt_on = 1'b1;
			else if (nv && nx == sctf_pkg::CH_STAR && !line_cmt_on &&
				block_depth != sctf_pkg::BLOCK_MAX)
				block_depth = block_depth + 16'd1;
		end
		if (c == sctf_pkg::CH_STAR && nv && nx == sctf_pkg::CH_SLASH && !slash_before &&
			!quoted() && !line_cmt_on && block_depth != 0)
			block_depth = block_depth - 16'd1;

		ws_before = prior_ws;
		ws = is_space(c);
		prior_ws = ws;
		prior_byte = c;
		prior_known = 1'b1;

		// output selection, first match wins
		if (!modes.strip_enable || (modes.strip_auto && brace_depth != 0)) begin
			got = 1'b1;
			r = make_result(c, sctf_pkg::ST_CHAR);
		end else if (modes.strip_comments && commented()) begin
		end else if (modes.strip_comments && !quoted() &&
			((c == sctf_pkg::CH_STAR && nv && nx == sctf_pkg::CH_SLASH) ||
			(star_before && c == sctf_pkg::CH_SLASH))) begin
		end else if (modes.strip_whitespace && ws && !quoted()) begin
		end else if (modes.compress_whitespace && ws) begin
			if (!ws_before) begin
				got = 1'b1;
				r = make_result(sctf_pkg::CH_SPACE, sctf_pkg::ST_CHAR);
			end
		end else if (modes.strip_quotes && (c == sctf_pkg::CH_DQ || c == sctf_pkg::CH_SQ)) begin
		end else if (quoted() && c == sctf_pkg::CH_BSL) begin
			// escape pair: successor is consumed and not tracked
			prior_known = 1'b0;
			prior_byte = '0;
			got = 1'b1;
			if (!nv) begin
				r = make_result(8'h00, sctf_pkg::ST_BAD_ESC);
			end else begin
				used = 1'b1;
				case (nx)
					sctf_pkg::CH_LC_R: r = make_result(sctf_pkg::CH_CR, sctf_pkg::ST_CHAR);
					sctf_pkg::CH_LC_N: r = make_result(sctf_pkg::CH_NL, sctf_pkg::ST_CHAR);
					sctf_pkg::CH_LC_T: r = make_result(sctf_pkg::CH_TAB, sctf_pkg::ST_CHAR);
					sctf_pkg::CH_NL: begin
						bump_lines();
						r = make_result(sctf_pkg::CH_NL, sctf_pkg::ST_CHAR);
					end
					sctf_pkg::CH_BSL, sctf_pkg::CH_SQ, sctf_pkg::CH_DQ:
						r = make_result(nx, sctf_pkg::ST_CHAR);
					default: r = make_result(nx, sctf_pkg::ST_BAD_ESC);
				endcase
			end
		end else begin
			folded = c;
			if (!modes.case_sensitive && !quoted()) begin
				if (modes.fold_upper && c >= sctf_pkg::CH_LC_A && c <= sctf_pkg::CH_LC_Z)
					folded = c - sctf_pkg::CASE_OFS;
				else if (!modes.fold_upper && c >= sctf_pkg::CH_UC_A &&
					c <= sctf_pkg::CH_UC_Z)
					folded = c + sctf_pkg::CASE_OFS;
			end
			got = 1'b1;
			r = make_result(folded, sctf_pkg::ST_CHAR);
		end
	endtask

	// One accepted input item: lookahead handling and expected results
	task automatic filter_step(input sctf_pkg::in_item_t it);
		sctf_pkg::out_item_t res[2];
		sctf_pkg::out_item_t r;
		int n;
		bit got, used;
		n = 0;
		if (it.end_of_data) begin
			if (la_full) begin
				scan_byte(la_byte, 1'b0, 8'h00, got, r, used);
				if (got) begin
					res[n] = r;
					n++;
				end
			end
			la_full = 1'b0;
			la_byte = '0;
			prior_known = 1'b0;
			prior_byte = '0;
			prior_ws = 1'b0;
			res[n] = make_result(8'h00, sctf_pkg::ST_END);
			n++;
		end else if (la_full) begin
			scan_byte(la_byte, 1'b1, it.in_byte, got, r, used);
			if (got) begin
				res[n] = r;
				n++;
			end
			if (used) begin
				la_full = 1'b0;
				la_byte = '0;
			end else begin
				la_byte = it.in_byte;
			end
		end else begin
			la_byte = it.in_byte;
			la_full = 1'b1;
		end
		if (n > 0)
			res[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			byte_results_due.push_back(res[i]);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, seen);
			errors++;
		end
	endtask

	// Stimulus helpers
	task automatic add_byte(input logic [7:0] b);
		sctf_pkg::in_item_t it;
		it.in_byte = b;
		it.end_of_data = 1'b0;
		bytes_to_send.push_back(it);
		phase_items++;
	endtask

	task automatic add_end();
		sctf_pkg::in_item_t it;
		it.in_byte = 8'($urandom_range(0, 255));
		it.end_of_data = 1'b1;
		bytes_to_send.push_back(it);
		phase_items++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 5))
			0: return sctf_pkg::CH_SPACE;
			1: return sctf_pkg::CH_TAB;
			2: return sctf_pkg::CH_NL;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return sctf_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] letter();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(sctf_pkg::CH_LC_A, sctf_pkg::CH_LC_Z));
		return 8'($urandom_range(sctf_pkg::CH_UC_A, sctf_pkg::CH_UC_Z));
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 9))
			0: return sctf_pkg::CH_LBRACE;
			1: return sctf_pkg::CH_RBRACE;
			2: return sctf_pkg::CH_DQ;
			3: return sctf_pkg::CH_SQ;
			4: return sctf_pkg::CH_SLASH;
			5: return sctf_pkg::CH_STAR;
			6: return sctf_pkg::CH_BSL;
			7: return sctf_pkg::CH_LC_R;
			8: return sctf_pkg::CH_LC_T;
			default: return ws_char();
		endcase
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 255));
			1: return special_char();
			2: return 8'($urandom_range(8'h30, 8'h39));
			default: return letter();
		endcase
	endfunction

	function automatic logic [7:0] escape_char();
		case ($urandom_range(0, 7))
			0: return sctf_pkg::CH_LC_R;
			1: return sctf_pkg::CH_LC_N;
			2: return sctf_pkg::CH_LC_T;
			3: return sctf_pkg::CH_NL;
			4: return sctf_pkg::CH_BSL;
			5: return sctf_pkg::CH_SQ;
			6: return sctf_pkg::CH_DQ;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed source fragments, some noise
	task automatic add_token();
		logic [7:0] q;
		case ($urandom_range(0, 11))
			0, 1: repeat ($urandom_range(1, 5)) add_byte(letter());
			2: repeat ($urandom_range(1, 4)) add_byte(ws_char());
			3, 4: begin
				q = $urandom_range(0, 2) ? sctf_pkg::CH_DQ : sctf_pkg::CH_SQ;
				add_byte(q);
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(0, 2) == 0) begin
						add_byte(sctf_pkg::CH_BSL);
						add_byte(escape_char());
					end else begin
						add_byte($urandom_range(0, 3) ? letter() : ws_char());
					end
				end
				add_byte(q);
			end
			5: begin
				add_byte(sctf_pkg::CH_SLASH);
				add_byte(sctf_pkg::CH_SLASH);
				repeat ($urandom_range(0, 4)) add_byte(any_char());
				add_byte(sctf_pkg::CH_NL);
			end
			6: begin
				add_text("/*");
				repeat ($urandom_range(0, 3)) add_byte(any_char());
				if ($urandom_range(0, 2) == 0)
					add_text(" /* x */");
				add_byte(letter());
				add_text("*/");
			end
			7: add_byte(sctf_pkg::CH_LBRACE);
			8: add_byte(sctf_pkg::CH_RBRACE);
			9: add_byte(8'($urandom_range(0, 255)));
			10: add_byte(any_char());
			default: begin
				if ($urandom_range(0, 2) == 0)
					add_end();
				else
					add_byte(sctf_pkg::CH_NL);
			end
		endcase
	endtask

	// Register writes, only while the block is idle
	task automatic write_reg(input logic [sctf_pkg::CFG_IW-1:0] idx, input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_modes(input sctf_pkg::cfg_t m);
		write_reg(sctf_pkg::CFG_STRIP_ENABLE, m.strip_enable);
		write_reg(sctf_pkg::CFG_STRIP_AUTO, m.strip_auto);
		write_reg(sctf_pkg::CFG_STRIP_COMMENTS, m.strip_comments);
		write_reg(sctf_pkg::CFG_STRIP_QUOTES, m.strip_quotes);
		write_reg(sctf_pkg::CFG_STRIP_WS, m.strip_whitespace);
		write_reg(sctf_pkg::CFG_COMPRESS_WS, m.compress_whitespace);
		write_reg(sctf_pkg::CFG_CASE_SENSITIVE, m.case_sensitive);
		write_reg(sctf_pkg::CFG_FOLD_UPPER, m.fold_upper);
		modes = m;
	endtask

	// Sender pauses until all items are out and every result is back
	task automatic drain();
		while (bytes_to_send.size() != 0 || src_valid || byte_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Bit order: enable, auto, comments, quotes, whitespace, compress, case, upper
	function automatic sctf_pkg::cfg_t phase_modes(int p);
		sctf_pkg::cfg_t m;
		case (p)
			0: m = 8'b1111_1010;
			1: m = 8'b0000_0000;
			2: m = 8'b1111_1111;
			3: m = 8'b1010_0100;
			4: m = 8'b1001_0101;
			5: m = 8'b1011_1001;
			default: begin
				m = sctf_pkg::cfg_t'(8'($urandom_range(0, 255)));
				m.strip_enable = ($urandom_range(0, 5) != 0);
			end
		endcase
		return m;
	endfunction

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, escapes, bad escape, nested and line comments,
		// escape at end, repeated end marker
		apply_modes(8'b1010_1001);
		add_byte(8'hFF);
		add_text("\"\\n\\q\"/*x/**/x*/{}//\n'\\");
		add_end();
		add_end();
		add_byte(8'h00);
		add_text("'");
		add_end();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			apply_modes(phase_modes(p));
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE)
				add_token();
			add_end();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && byte_results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Driver: bursts of items with random gaps
	int burst_left = 8;
	int gap_left = 0;
	bit src_taken = 1'b0;

	always @(negedge clk) begin
		if (arst_n && (!src_valid || src_taken)) begin
			src_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				src_valid <= 1'b0;
			end else if (bytes_to_send.size() > 0) begin
				src_data <= bytes_to_send.pop_front();
				src_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern that changes mode now and then, one long hold
	int  hold_left = 0;
	bit  long_hold_done = 1'b0;
	int  rx_mode = 0;
	int  rx_left = 0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			dst_ready <= 1'b0;
		end else if (!long_hold_done && bytes_taken >= HOLD_AFTER) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			dst_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(8, 64);
			end
			rx_left--;
			case (rx_mode)
				0: dst_ready <= 1'b1;
				1: dst_ready <= ($urandom_range(0, 3) != 0);
				2: dst_ready <= $urandom_range(0, 1);
				default: dst_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor and predictor, both at the rising edge
	always @(posedge clk) begin : monitor
		sctf_pkg::out_item_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (byte_results_due.size() == 0) begin
				$display("%0t: result expected none got out_byte %0h status %0d",
					$time, dst_data.out_byte, dst_data.status);
				errors++;
			end else begin
				want = byte_results_due.pop_front();
				compare_field("out_byte", want.out_byte, dst_data.out_byte);
				compare_field("status", want.status, dst_data.status);
				compare_field("last_of_run", want.last_of_run, dst_data.last_of_run);
				compare_field("line_number", want.line_number, dst_data.line_number);
				compare_field("brace_level", want.brace_level, dst_data.brace_level);
			end
		end
		if (arst_n && src_valid && src_ready) begin
			filter_step(src_data);
			src_taken = 1'b1;
			bytes_taken++;
		end
	end

	// Watchdog on cycles with no handshake and no register write
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((src_valid && src_ready) || (dst_valid && dst_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
